>>> rtl/pqnp_pkg.sv
// Types, constants and helper functions shared by the palette quantizer.
`timescale 1ns / 1ps
`default_nettype none

package pqnp_pkg;

    localparam int CHAN_W  = 8;
    localparam int IDX_W   = 4;
    localparam int PAL_N   = 16;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;
    localparam int COUNT_W = 6;
    localparam int QUAD_SZ = 4;
    localparam int QUAD_N  = PAL_N / QUAD_SZ;

    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [SQ_W-1:0]    t_sq;
    typedef logic [DIST_W-1:0]  t_dist;
    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    typedef struct packed {
        logic emit;
        logic odd_col;
        logic last_col;
        logic last_row;
    } t_pos;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    typedef struct packed {
        t_dist sqdist;
        t_idx  idx;
    } t_cand;

    localparam t_rgb PALETTE [PAL_N] = '{
        '{8'd0,   8'd0,   8'd0  },
        '{8'd0,   8'd0,   8'd255},
        '{8'd0,   8'd255, 8'd0  },
        '{8'd0,   8'd255, 8'd255},
        '{8'd255, 8'd0,   8'd0  },
        '{8'd255, 8'd0,   8'd255},
        '{8'd165, 8'd42,  8'd42 },
        '{8'd192, 8'd192, 8'd192},
        '{8'd128, 8'd128, 8'd128},
        '{8'd0,   8'd0,   8'd255},
        '{8'd0,   8'd255, 8'd0  },
        '{8'd0,   8'd255, 8'd255},
        '{8'd255, 8'd0,   8'd0  },
        '{8'd255, 8'd0,   8'd255},
        '{8'd255, 8'd255, 8'd0  },
        '{8'd255, 8'd255, 8'd255}
    };

    function automatic t_sq sq_diff(input t_chan a, input t_chan b);
        t_chan d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    // keep a on a tie: a always carries the lower index
    function automatic t_cand pick(input t_cand a, input t_cand b);
        return (b.sqdist < a.sqdist) ? b : a;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pqnp_if.sv
// Valid/ready channel interfaces for pixels in and packed bytes out.
`timescale 1ns / 1ps
`default_nettype none

interface pqnp_pix_if;
    logic            valid;
    logic            ready;
    pqnp_pkg::t_chan red;
    pqnp_pkg::t_chan green;
    pqnp_pkg::t_chan blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface pqnp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output packed_byte, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input packed_byte, input row_end, input frame_end,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pqnp_nearest.sv
// Pipelined nearest-palette search: squares, distance sums, quad minimum, final pick.
`timescale 1ns / 1ps
`default_nettype none

module pqnp_nearest (
    input  logic                 i_clk,
    input  pqnp_pkg::t_stage_en  i_en,
    input  pqnp_pkg::t_rgb       i_pix,
    output pqnp_pkg::t_idx       o_index
);

    pqnp_pkg::t_sq   r_sq   [pqnp_pkg::PAL_N][3];
    pqnp_pkg::t_dist r_dist [pqnp_pkg::PAL_N];
    pqnp_pkg::t_cand r_quad [pqnp_pkg::QUAD_N];
    pqnp_pkg::t_cand n_quad [pqnp_pkg::QUAD_N];
    pqnp_pkg::t_cand w_best;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int i = 0; i < pqnp_pkg::PAL_N; i++) begin
                r_sq[i][0] <= pqnp_pkg::sq_diff(i_pix.red,   pqnp_pkg::PALETTE[i].red);
                r_sq[i][1] <= pqnp_pkg::sq_diff(i_pix.green, pqnp_pkg::PALETTE[i].green);
                r_sq[i][2] <= pqnp_pkg::sq_diff(i_pix.blue,  pqnp_pkg::PALETTE[i].blue);
            end
        end
        if (i_en.s2) begin
            for (int i = 0; i < pqnp_pkg::PAL_N; i++) begin
                r_dist[i] <= pqnp_pkg::DIST_W'(r_sq[i][0]) + pqnp_pkg::DIST_W'(r_sq[i][1])
                           + pqnp_pkg::DIST_W'(r_sq[i][2]);
            end
        end
        if (i_en.s3) begin
            r_quad <= n_quad;
        end
    end

    always_comb begin
        for (int q = 0; q < pqnp_pkg::QUAD_N; q++) begin
            n_quad[q] = '{sqdist: r_dist[q*pqnp_pkg::QUAD_SZ],
                          idx:    pqnp_pkg::IDX_W'(q*pqnp_pkg::QUAD_SZ)};
            for (int k = 1; k < pqnp_pkg::QUAD_SZ; k++) begin
                n_quad[q] = pqnp_pkg::pick(n_quad[q],
                    '{sqdist: r_dist[q*pqnp_pkg::QUAD_SZ+k],
                      idx:    pqnp_pkg::IDX_W'(q*pqnp_pkg::QUAD_SZ+k)});
            end
        end
    end

    always_comb begin
        w_best = r_quad[0];
        for (int q = 1; q < pqnp_pkg::QUAD_N; q++) begin
            w_best = pqnp_pkg::pick(w_best, r_quad[q]);
        end
    end

    assign o_index = w_best.idx;

endmodule

`default_nettype wire

>>> rtl/palette_quantize_nibble_pack.sv
// Top level: 16-entry palette quantizer with two-index-per-byte packing.
`timescale 1ns / 1ps
`default_nettype none

// Takes one RGB pixel per clock in raster order over an IMAGE_SIDE x IMAGE_SIDE
// image and maps it to the nearest of 16 fixed palette entries (least squared
// distance, lower index on a tie). Two indices go out per byte, even column in
// the high nibble; an odd side sends the last pixel of each row alone in the
// high nibble. row_end and frame_end mark the last byte of a row and image.
// Throughput is one pixel per clock unless the output stalls; a pixel passes
// through the input register, the square, sum and quad-minimum registers and
// the output register. Every stage holds its own valid bit, so pixels keep
// entering while bubbles remain ahead of a stalled output byte.

module palette_quantize_nibble_pack #(
    parameter int IMAGE_SIDE = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pqnp_pix_if.sink      i_pix,
    pqnp_byte_if.source   o_byte
);

    localparam pqnp_pkg::t_count COUNT_LAST = pqnp_pkg::COUNT_W'(IMAGE_SIDE - 1);

    pqnp_pkg::t_count r_col;
    pqnp_pkg::t_count r_row;
    pqnp_pkg::t_idx   r_held;
    pqnp_pkg::t_rgb   r_pix0;
    pqnp_pkg::t_pos   r_pos0;
    pqnp_pkg::t_pos   r_pos1;
    pqnp_pkg::t_pos   r_pos2;
    pqnp_pkg::t_pos   r_pos3;
    pqnp_pkg::t_pos   n_pos;
    logic             r_v0;
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_row_end;
    logic             r_out_frame_end;
    logic [7:0]       n_out_byte;

    logic                en_out;
    logic                consume3;
    logic                en0;
    logic                accept;
    pqnp_pkg::t_stage_en stage_en;
    pqnp_pkg::t_idx      index;

    assign en_out      = !r_out_valid || o_byte.ready;
    assign consume3    = r_v3 && (!r_pos3.emit || en_out);
    assign stage_en.s3 = !r_v3 || consume3;
    assign stage_en.s2 = !r_v2 || stage_en.s3;
    assign stage_en.s1 = !r_v1 || stage_en.s2;
    assign en0         = !r_v0 || stage_en.s1;
    assign accept      = i_pix.valid && en0;

    assign i_pix.ready = en0;

    always_comb begin
        n_pos.odd_col  = r_col[0];
        n_pos.last_col = (r_col >= COUNT_LAST);
        n_pos.last_row = (r_row >= COUNT_LAST);
        n_pos.emit     = n_pos.odd_col || n_pos.last_col;
    end

    always_comb begin
        if (r_pos3.odd_col) begin
            n_out_byte = {r_held, index};
        end else begin
            n_out_byte = {index, pqnp_pkg::IDX_W'(0)};
        end
    end

    pqnp_nearest u_nearest (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_pix   (r_pix0),
        .o_index (index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_held      <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en0)         r_v0 <= i_pix.valid;
            if (stage_en.s1) r_v1 <= r_v0;
            if (stage_en.s2) r_v2 <= r_v1;
            if (stage_en.s3) r_v3 <= r_v2;
            if (accept) begin
                if (n_pos.last_col) begin
                    r_col <= '0;
                    r_row <= n_pos.last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (consume3 && !r_pos3.emit) begin
                r_held <= index;
            end
            if (consume3 && r_pos3.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_pix0.red   <= i_pix.red;
            r_pix0.green <= i_pix.green;
            r_pix0.blue  <= i_pix.blue;
            r_pos0       <= n_pos;
        end
        if (stage_en.s1) r_pos1 <= r_pos0;
        if (stage_en.s2) r_pos2 <= r_pos1;
        if (stage_en.s3) r_pos3 <= r_pos2;
        if (consume3 && r_pos3.emit) begin
            r_out_byte      <= n_out_byte;
            r_out_row_end   <= r_pos3.last_col;
            r_out_frame_end <= r_pos3.last_col && r_pos3.last_row;
        end
    end

    assign o_byte.valid       = r_out_valid;
    assign o_byte.packed_byte = r_out_byte;
    assign o_byte.row_end     = r_out_row_end;
    assign o_byte.frame_end   = r_out_frame_end;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COUNT_LAST) && (r_row <= COUNT_LAST))
        else $error("position counter out of range");

    a_frame_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte.valid && o_byte.frame_end |-> o_byte.row_end)
        else $error("frame end without row end");

    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v0 |-> i_pix.ready)
        else $error("input stalled with empty input register");

    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume3 && r_pos3.emit |=> o_byte.valid)
        else $error("emitting transaction lost");

endmodule

`default_nettype wire
